@@ src/crbm_pkg.sv @@
// Package for the coverage bitmap region mapper: widths, opcodes, FSM states
// and the structs passed between the mapper's modules. No dependencies.
package crbm_pkg;

  // Binary and bitmap geometry
  localparam int BIN_CAPACITY = 65536;
  localparam int WORD_W       = 32;
  localparam int WORD_IDX_W   = $clog2(WORD_W);
  localparam int FFS_W        = WORD_IDX_W + 1;
  localparam int MAP_WORDS    = BIN_CAPACITY / WORD_W;
  localparam int MAP_AW       = $clog2(MAP_WORDS);

  // Field widths
  localparam int OP_W  = 2;
  localparam int OFF_W = 16;
  localparam int LEN_W = 17;
  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Per-request region cap and result buffer
  localparam int MAX_REGIONS = 64;
  localparam int REG_CNT_W   = $clog2(MAX_REGIONS + 1);
  localparam int BUF_AW      = $clog2(MAX_REGIONS);

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_BIN_LENGTH = 1'b0;
  localparam logic REG_MAX_BLOCK  = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_SKIP   = 2'd1,
    OP_UNSKIP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_LD,
    S_SCAN,
    S_FIN,
    S_ORD,
    S_OWR
  } state_t;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [LEN_W-1:0] bin_length;
    logic [LEN_W-1:0] max_block;
    logic             wipe;
  } cfg_t;

  // Result buffer entry and write request
  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } bufent_t;

  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] idx;
    bufent_t           ent;
  } bufwr_t;

endpackage

@@ src/crbm_if.sv @@
// Request and result channel interfaces of the coverage bitmap region mapper.
// Depends on crbm_pkg for field widths.
interface crbm_in_if;
  logic                        valid;
  logic                        ready;
  logic [crbm_pkg::OP_W-1:0]   opcode;
  logic [crbm_pkg::OFF_W-1:0]  start_offset;
  logic [crbm_pkg::LEN_W-1:0]  range_length;

  modport source(output valid, output opcode, output start_offset, output range_length,
                 input ready);
  modport sink(input valid, input opcode, input start_offset, input range_length,
               output ready);
endinterface

interface crbm_out_if;
  logic                        valid;
  logic                        ready;
  logic [crbm_pkg::OFF_W-1:0]  region_offset;
  logic [crbm_pkg::LEN_W-1:0]  region_length;
  logic                        last_result;
  logic                        truncated;
  logic [crbm_pkg::LEN_W-1:0]  resume_offset;
  logic [crbm_pkg::CNT_W-1:0]  mapped_total;
  logic                        map_complete;

  modport source(output valid, output region_offset, output region_length,
                 output last_result, output truncated, output resume_offset,
                 output mapped_total, output map_complete, input ready);
  modport sink(input valid, input region_offset, input region_length,
               input last_result, input truncated, input resume_offset,
               input mapped_total, input map_complete, output ready);
endinterface

@@ src/crbm_ffs.sv @@
// Shared find-first-set unit: lowest set bit of one bitmap word.
// Depends on crbm_pkg for the word width.
module crbm_ffs (
  input  logic [crbm_pkg::WORD_W-1:0] vec,
  output logic [crbm_pkg::FFS_W-1:0]  idx
);

  // Priority encode, WORD_W when no bit is set
  always_comb begin
    idx = crbm_pkg::FFS_W'(crbm_pkg::WORD_W);
    for (int i = crbm_pkg::WORD_W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = crbm_pkg::FFS_W'(i);
      end
    end
  end

endmodule

@@ src/crbm_result_buf.sv @@
// Result buffer: holds the regions of one request until its totals are known.
// Depends on crbm_pkg for the entry and write request structs.
module crbm_result_buf (
  input  logic                        clk,
  input  crbm_pkg::bufwr_t            wr,
  input  logic [crbm_pkg::BUF_AW-1:0] rd_idx,
  output crbm_pkg::bufent_t           rd_q
);

  crbm_pkg::bufent_t mem [crbm_pkg::MAX_REGIONS];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.idx] <= wr.ent;
    end
    rd_q <= mem[rd_idx];
  end

endmodule

@@ src/crbm_cfg_regs.sv @@
// APB-style configuration registers: bin_length and the block size limit.
// Depends on crbm_pkg; a bin_length write raises a one-cycle wipe request.
module crbm_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crbm_pkg::APB_AW-1:0] paddr,
  input  logic [crbm_pkg::APB_DW-1:0] pwdata,
  output logic [crbm_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output crbm_pkg::cfg_t              cfg
);

  logic [crbm_pkg::LEN_W-1:0] bin_length_r;
  logic [crbm_pkg::LEN_W-1:0] max_block_r;
  logic                       wipe_r;
  logic                       wr_en;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_length_r <= '0;
      max_block_r  <= '0;
      wipe_r       <= 1'b0;
    end else begin
      wipe_r <= 1'b0;
      if (wr_en) begin
        if (reg_sel == crbm_pkg::REG_BIN_LENGTH) begin
          bin_length_r <= pwdata[crbm_pkg::LEN_W-1:0];
          wipe_r       <= 1'b1;
        end else begin
          max_block_r <= pwdata[crbm_pkg::LEN_W-1:0];
        end
      end
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      crbm_pkg::REG_BIN_LENGTH: prdata = crbm_pkg::APB_DW'(bin_length_r);
      crbm_pkg::REG_MAX_BLOCK:  prdata = crbm_pkg::APB_DW'(max_block_r);
      default:                  prdata = '0;
    endcase
  end

  assign cfg.bin_length = bin_length_r;
  assign cfg.max_block  = max_block_r;
  assign cfg.wipe       = wipe_r;

endmodule

@@ src/coverage_bitmap_region_mapper.sv @@
// Coverage bitmap region mapper top level: sequencer, bitmap memory, output register.
// Depends on crbm_pkg, crbm_if, crbm_ffs, crbm_result_buf and crbm_cfg_regs.
// Sequence: scan the range a run, gap, block split or cap stop at a time, fetching and
//   writing back each bitmap word touched, then hand out the results one by one.
// One request at a time; a clear request holds ready low while the bitmap is zeroed.
// Reset and bin_length writes run a clearing pass over every bitmap word with ready held low.
module coverage_bitmap_region_mapper (
  input  logic                        clk,
  input  logic                        rst_n,
  crbm_in_if.sink                     in_ch,
  crbm_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crbm_pkg::APB_AW-1:0] paddr,
  input  logic [crbm_pkg::APB_DW-1:0] pwdata,
  output logic [crbm_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int WW  = crbm_pkg::WORD_W;
  localparam int WIW = crbm_pkg::WORD_IDX_W;
  localparam int FW  = crbm_pkg::FFS_W;
  localparam int AW  = crbm_pkg::MAP_AW;
  localparam int PW  = crbm_pkg::LEN_W;
  localparam int OW  = crbm_pkg::OFF_W;
  localparam int CW  = crbm_pkg::CNT_W;
  localparam int NW  = crbm_pkg::REG_CNT_W;
  localparam int BW  = crbm_pkg::BUF_AW;

  crbm_pkg::cfg_t    cfg;
  crbm_pkg::bufwr_t  bufwr;
  crbm_pkg::bufent_t buf_q;
  logic [BW-1:0]     buf_ridx;

  crbm_pkg::state_t state_r, state_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] end_r, end_nxt;
  logic [AW-1:0] waddr_r, waddr_nxt;
  logic [WW-1:0] wd_r, wd_nxt;
  logic          app_r, app_nxt;
  logic          unsk_r, unsk_nxt;
  logic          in_run_r, in_run_nxt;
  logic [OW-1:0] run_start_r, run_start_nxt;
  logic [PW-1:0] run_len_r, run_len_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          trunc_r, trunc_nxt;
  logic [PW-1:0] resume_r, resume_nxt;
  logic [CW-1:0] marked_r, marked_nxt;
  logic [CW-1:0] mapped_r, mapped_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          ack_pend_r, ack_pend_nxt;
  logic [NW-1:0] out_idx_r, out_idx_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [OW-1:0] out_off_r, out_off_nxt;
  logic [PW-1:0] out_len_r, out_len_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_trunc_r, out_trunc_nxt;
  logic [PW-1:0] out_resume_r, out_resume_nxt;
  logic [CW-1:0] out_mapped_r, out_mapped_nxt;
  logic          out_cmpl_r, out_cmpl_nxt;

  // Bitmap memory ports
  logic [WW-1:0] map_mem [crbm_pkg::MAP_WORDS];
  logic [WW-1:0] map_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [WW-1:0] mem_wdata;

  // Scan datapath
  logic [PW-1:0]  bl;
  logic [PW:0]    req_sum;
  logic [WIW-1:0] bpos;
  logic [WW-1:0]  xw;
  logic           cur_done;
  logic [WW-1:0]  ge_mask;
  logic [WW-1:0]  srch;
  logic [FW-1:0]  ffs_idx;
  logic [PW-1:0]  word_base;
  logic [PW-1:0]  cand;
  logic [PW-1:0]  jump_end;
  logic [PW-1:0]  rl_base;
  logic [PW:0]    budget_end;
  logic           use_budget;
  logic [PW-1:0]  seg_end;
  logic [FW-1:0]  seg_len;
  logic [FW-1:0]  seg_hi;
  logic [WW-1:0]  run_mask;
  logic [CW:0]    mapped_sum;
  logic           emit;
  logic           out_load;
  logic           out_is_last;

  crbm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crbm_result_buf u_buf (
    .clk    (clk),
    .wr     (bufwr),
    .rd_idx (buf_ridx),
    .rd_q   (buf_q)
  );

  crbm_ffs u_ffs (
    .vec (srch),
    .idx (ffs_idx)
  );

  // Effective binary length and clipped request end
  assign bl      = (cfg.bin_length > PW'(crbm_pkg::BIN_CAPACITY)) ?
                   PW'(crbm_pkg::BIN_CAPACITY) : cfg.bin_length;
  assign req_sum = (PW+1)'(in_ch.start_offset) + (PW+1)'(in_ch.range_length);

  // One segment step over the held word: find where the current run or gap ends
  assign bpos      = pos_r[WIW-1:0];
  assign xw        = wd_r ^ {WW{unsk_r}};
  assign cur_done  = xw[bpos];
  assign ge_mask   = {WW{1'b1}} << bpos;
  assign srch      = (cur_done ? ~xw : xw) & ge_mask;
  assign word_base = {1'b0, waddr_r, {WIW{1'b0}}};
  assign cand      = word_base + PW'(ffs_idx);
  assign jump_end  = (cand < end_r) ? cand : end_r;
  assign rl_base   = in_run_r ? run_len_r : '0;
  assign budget_end = (PW+1)'(pos_r) + (PW+1)'(cfg.max_block) - (PW+1)'(rl_base);
  assign use_budget = app_r && (cfg.max_block != '0) &&
                      (budget_end < (PW+1)'(jump_end));
  assign seg_end   = use_budget ? budget_end[PW-1:0] : jump_end;
  assign seg_len   = FW'(seg_end - pos_r);
  assign seg_hi    = FW'(seg_end - word_base);
  assign run_mask  = ge_mask & ~({WW{1'b1}} << seg_hi);
  assign mapped_sum = (CW+1)'(mapped_r) + (CW+1)'(run_len_r);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    end_nxt       = end_r;
    waddr_nxt     = waddr_r;
    wd_nxt        = wd_r;
    app_nxt       = app_r;
    unsk_nxt      = unsk_r;
    in_run_nxt    = in_run_r;
    run_start_nxt = run_start_r;
    run_len_nxt   = run_len_r;
    n_nxt         = n_r;
    trunc_nxt     = trunc_r;
    resume_nxt    = resume_r;
    marked_nxt    = marked_r;
    mapped_nxt    = mapped_r;
    clr_cnt_nxt   = clr_cnt_r;
    ack_pend_nxt  = ack_pend_r;
    out_idx_nxt   = out_idx_r;
    mem_we        = 1'b0;
    mem_waddr     = waddr_r;
    mem_wdata     = wd_r;
    mem_raddr     = waddr_r;
    buf_ridx      = out_idx_r[BW-1:0];
    emit          = 1'b0;
    out_load      = 1'b0;
    out_is_last   = 1'b0;

    unique case (state_r)
      // Zero the bitmap one word a cycle
      crbm_pkg::S_CLR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(crbm_pkg::MAP_WORDS - 1)) begin
          state_nxt    = ack_pend_r ? crbm_pkg::S_OWR : crbm_pkg::S_IDLE;
          ack_pend_nxt = 1'b0;
        end
      end

      // Take a request and fetch its first word
      crbm_pkg::S_IDLE: begin
        mem_raddr = in_ch.start_offset[OW-1:WIW];
        if (in_ch.valid && !cfg.wipe) begin
          pos_nxt    = PW'(in_ch.start_offset);
          end_nxt    = (req_sum > (PW+1)'(bl)) ? bl : req_sum[PW-1:0];
          waddr_nxt  = in_ch.start_offset[OW-1:WIW];
          app_nxt    = (in_ch.opcode == crbm_pkg::OP_APPEND);
          unsk_nxt   = (in_ch.opcode == crbm_pkg::OP_UNSKIP);
          in_run_nxt = 1'b0;
          n_nxt      = '0;
          trunc_nxt  = 1'b0;
          resume_nxt = '0;
          out_idx_nxt = '0;
          if (in_ch.opcode == crbm_pkg::OP_CLEAR) begin
            marked_nxt   = '0;
            mapped_nxt   = '0;
            clr_cnt_nxt  = '0;
            ack_pend_nxt = 1'b1;
            state_nxt    = crbm_pkg::S_CLR;
          end else begin
            state_nxt = crbm_pkg::S_LD;
          end
        end
      end

      crbm_pkg::S_LD: begin
        wd_nxt    = map_q;
        state_nxt = crbm_pkg::S_SCAN;
      end

      crbm_pkg::S_SCAN: begin
        if (pos_r >= end_r) begin
          // range done: write the word back
          mem_we    = 1'b1;
          state_nxt = crbm_pkg::S_FIN;
        end else if (cur_done) begin
          // already in the wanted state: close any run and jump the gap
          if (app_r && in_run_r) begin
            emit       = 1'b1;
            in_run_nxt = 1'b0;
          end
          pos_nxt = jump_end;
        end else if (app_r && !in_run_r && (n_r == NW'(crbm_pkg::MAX_REGIONS))) begin
          // region cap with bytes left to map
          trunc_nxt  = 1'b1;
          resume_nxt = pos_r;
          mem_we     = 1'b1;
          state_nxt  = crbm_pkg::S_FIN;
        end else if (app_r && in_run_r && (cfg.max_block != '0) &&
                     (run_len_r == cfg.max_block)) begin
          // block size reached: close the piece, the next one starts here
          emit       = 1'b1;
          in_run_nxt = 1'b0;
        end else begin
          // mark or unmark the segment
          wd_nxt  = unsk_r ? (wd_r & ~run_mask) : (wd_r | run_mask);
          pos_nxt = seg_end;
          marked_nxt = unsk_r ? (marked_r - CW'(seg_len)) : (marked_r + CW'(seg_len));
          if (app_r) begin
            in_run_nxt    = 1'b1;
            run_start_nxt = in_run_r ? run_start_r : pos_r[OW-1:0];
            run_len_nxt   = rl_base + PW'(seg_len);
          end
        end
        // crossed into another word: write back, fetch the next one if the range goes on
        if ((state_nxt == crbm_pkg::S_SCAN) &&
            (pos_nxt[PW-1:WIW] != {1'b0, waddr_r})) begin
          mem_we    = 1'b1;
          mem_wdata = wd_nxt;
          if (pos_nxt < end_r) begin
            mem_raddr = pos_nxt[OW-1:WIW];
            waddr_nxt = pos_nxt[OW-1:WIW];
            state_nxt = crbm_pkg::S_LD;
          end else begin
            state_nxt = crbm_pkg::S_FIN;
          end
        end
      end

      // Close an open run
      crbm_pkg::S_FIN: begin
        if (app_r && in_run_r) begin
          emit       = 1'b1;
          in_run_nxt = 1'b0;
        end
        out_idx_nxt = '0;
        state_nxt   = crbm_pkg::S_ORD;
      end

      crbm_pkg::S_ORD: begin
        state_nxt = crbm_pkg::S_OWR;
      end

      // Hand one result to the output register
      crbm_pkg::S_OWR: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load    = 1'b1;
          out_is_last = (n_r == '0) || ((out_idx_r + NW'(1)) == n_r);
          out_idx_nxt = out_idx_r + NW'(1);
          state_nxt   = out_is_last ? crbm_pkg::S_IDLE : crbm_pkg::S_ORD;
        end
      end

      default: state_nxt = crbm_pkg::S_IDLE;
    endcase

    // Record a finished region
    bufwr.we      = emit;
    bufwr.idx     = n_r[BW-1:0];
    bufwr.ent.off = run_start_r;
    bufwr.ent.len = run_len_r;
    if (emit) begin
      n_nxt      = n_r + NW'(1);
      mapped_nxt = mapped_sum[CW] ? crbm_pkg::CNT_MAX : mapped_sum[CW-1:0];
    end

    // bin_length write wipes the map
    if (cfg.wipe) begin
      marked_nxt  = '0;
      mapped_nxt  = '0;
      clr_cnt_nxt = '0;
      state_nxt   = crbm_pkg::S_CLR;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_off_nxt    = out_off_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;
    out_trunc_nxt  = out_trunc_r;
    out_resume_nxt = out_resume_r;
    out_mapped_nxt = out_mapped_r;
    out_cmpl_nxt   = out_cmpl_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_off_nxt    = (n_r == '0) ? '0 : buf_q.off;
      out_len_nxt    = (n_r == '0) ? '0 : buf_q.len;
      out_last_nxt   = out_is_last;
      out_trunc_nxt  = out_is_last && trunc_r;
      out_resume_nxt = out_is_last ? resume_r : '0;
      out_mapped_nxt = mapped_r;
      out_cmpl_nxt   = (marked_r == bl);
    end
  end

  // Bitmap memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    map_q <= map_mem[mem_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crbm_pkg::S_CLR;
      in_run_r    <= 1'b0;
      n_r         <= '0;
      trunc_r     <= 1'b0;
      marked_r    <= '0;
      mapped_r    <= '0;
      clr_cnt_r   <= '0;
      ack_pend_r  <= 1'b0;
      out_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_run_r    <= in_run_nxt;
      n_r         <= n_nxt;
      trunc_r     <= trunc_nxt;
      marked_r    <= marked_nxt;
      mapped_r    <= mapped_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ack_pend_r  <= ack_pend_nxt;
      out_idx_r   <= out_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    end_r        <= end_nxt;
    waddr_r      <= waddr_nxt;
    wd_r         <= wd_nxt;
    app_r        <= app_nxt;
    unsk_r       <= unsk_nxt;
    run_start_r  <= run_start_nxt;
    run_len_r    <= run_len_nxt;
    resume_r     <= resume_nxt;
    out_off_r    <= out_off_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
    out_trunc_r  <= out_trunc_nxt;
    out_resume_r <= out_resume_nxt;
    out_mapped_r <= out_mapped_nxt;
    out_cmpl_r   <= out_cmpl_nxt;
  end

  // No request is taken in the cycle a bin_length write starts the wipe
  assign in_ch.ready          = (state_r == crbm_pkg::S_IDLE) && !cfg.wipe;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.region_offset = out_off_r;
  assign out_ch.region_length = out_len_r;
  assign out_ch.last_result   = out_last_r;
  assign out_ch.truncated     = out_trunc_r;
  assign out_ch.resume_offset = out_resume_r;
  assign out_ch.mapped_total  = out_mapped_r;
  assign out_ch.map_complete  = out_cmpl_r;

  // Region count never passes the cap
  assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(crbm_pkg::MAX_REGIONS))
    else $error("region count above cap");

  // Marked bytes never exceed the bitmap size
  assert property (@(posedge clk) disable iff (!rst_n)
    marked_r <= CW'(crbm_pkg::BIN_CAPACITY))
    else $error("marked count out of range");

  // Scan position only moves forward
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == crbm_pkg::S_SCAN && $past(state_r) == crbm_pkg::S_SCAN)
      |-> pos_r >= $past(pos_r))
    else $error("scan position moved backward");

  // An open piece never exceeds the block size limit
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_run_r && cfg.max_block != '0) |-> run_len_r <= cfg.max_block)
    else $error("piece longer than block size");

endmodule

@@ tb/tb_coverage_bitmap_region_mapper.sv @@
// Self-checking testbench for coverage_bitmap_region_mapper: directed and random
// requests, APB register writes, per-field result checks. Depends on crbm_pkg,
// crbm_if and the mapper RTL.
module tb_coverage_bitmap_region_mapper;

  localparam logic [crbm_pkg::APB_AW-1:0] ADDR_BIN_LENGTH = {crbm_pkg::REG_BIN_LENGTH, 2'b00};
  localparam logic [crbm_pkg::APB_AW-1:0] ADDR_MAX_BLOCK  = {crbm_pkg::REG_MAX_BLOCK, 2'b00};
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 600;
  localparam int END_SETTLE     = 100;

  typedef struct packed {
    crbm_pkg::op_t              op;
    logic [crbm_pkg::OFF_W-1:0] start;
    logic [crbm_pkg::LEN_W-1:0] len;
  } map_req_t;

  typedef struct packed {
    logic [crbm_pkg::OFF_W-1:0] off;
    logic [crbm_pkg::LEN_W-1:0] len;
    logic                       last;
    logic                       trunc;
    logic [crbm_pkg::LEN_W-1:0] resume;
    logic [crbm_pkg::CNT_W-1:0] total;
    logic                       complete;
  } region_rec_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // APB side
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [crbm_pkg::APB_AW-1:0] paddr   = '0;
  logic [crbm_pkg::APB_DW-1:0] pwdata  = '0;
  logic [crbm_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  // Request and result channels
  crbm_in_if  in_ch();
  crbm_out_if out_ch();

  logic     drv_valid  = 1'b0;
  map_req_t drv_req    = '0;
  logic     sink_ready = 1'b0;

  assign in_ch.valid        = drv_valid;
  assign in_ch.opcode       = drv_req.op;
  assign in_ch.start_offset = drv_req.start;
  assign in_ch.range_length = drv_req.len;
  assign out_ch.ready       = sink_ready;

  coverage_bitmap_region_mapper u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // Shadow of the mapper: bitmap, counters and registers
  bit          cov_map [crbm_pkg::BIN_CAPACITY];
  int unsigned marked_cnt = 0;
  int unsigned mapped_cnt = 0;
  int unsigned bin_len    = 0;
  int unsigned max_blk    = 0;

  map_req_t    req_pending[$];
  region_rec_t region_exp[$];
  int          mismatches = 0;

  logic long_hold_req  = 1'b0;
  logic long_hold_done = 1'b0;

  function automatic void wipe_map();
    foreach (cov_map[i]) cov_map[i] = 1'b0;
    marked_cnt = 0;
    mapped_cnt = 0;
  endfunction

  function automatic void set_cov(int unsigned pos, bit val);
    if (val && !cov_map[pos]) begin
      cov_map[pos] = 1'b1;
      marked_cnt++;
    end else if (!val && cov_map[pos]) begin
      cov_map[pos] = 1'b0;
      marked_cnt--;
    end
  endfunction

  function automatic void apply_config(logic [crbm_pkg::APB_AW-1:0] addr,
                                       logic [crbm_pkg::APB_DW-1:0] data);
    if (addr == ADDR_BIN_LENGTH) begin
      bin_len = 32'(data[crbm_pkg::LEN_W-1:0]);
      wipe_map();
    end else if (addr == ADDR_MAX_BLOCK) begin
      max_blk = 32'(data[crbm_pkg::LEN_W-1:0]);
    end
  endfunction

  // Work out the regions one request produces and queue them
  function automatic void predict_regions(map_req_t req);
    int unsigned span;
    int unsigned stop;
    int unsigned pos;
    int unsigned run_start;
    int unsigned run_len;
    int unsigned resume;
    bit          cut;
    region_rec_t regs[$];
    region_rec_t rec;
    span   = (bin_len > crbm_pkg::BIN_CAPACITY) ? crbm_pkg::BIN_CAPACITY : bin_len;
    stop   = 32'(req.start) + 32'(req.len);
    if (stop > span) stop = span;
    cut    = 1'b0;
    resume = 0;
    case (req.op) inside
      crbm_pkg::OP_APPEND: begin
        pos = 32'(req.start);
        while (pos < stop && !cut) begin
          if (cov_map[pos]) begin
            pos++;
          end else if (regs.size() >= crbm_pkg::MAX_REGIONS) begin
            cut    = 1'b1;
            resume = pos;
          end else begin
            run_start = pos;
            run_len   = 0;
            while (pos < stop && !cov_map[pos] && (max_blk == 0 || run_len < max_blk)) begin
              set_cov(pos, 1'b1);
              pos++;
              run_len++;
            end
            rec     = '0;
            rec.off = run_start[crbm_pkg::OFF_W-1:0];
            rec.len = run_len[crbm_pkg::LEN_W-1:0];
            regs.push_back(rec);
            mapped_cnt = (mapped_cnt + run_len > 32'(crbm_pkg::CNT_MAX)) ?
                         32'(crbm_pkg::CNT_MAX) : mapped_cnt + run_len;
          end
        end
      end
      crbm_pkg::OP_SKIP, crbm_pkg::OP_UNSKIP: begin
        for (pos = 32'(req.start); pos < stop; pos++)
          set_cov(pos, req.op == crbm_pkg::OP_SKIP);
      end
      default: begin
        wipe_map();
      end
    endcase
    // acknowledge-only result when nothing was mapped
    if (regs.size() == 0) begin
      rec = '0;
      regs.push_back(rec);
    end
    foreach (regs[i]) begin
      regs[i].total    = mapped_cnt[crbm_pkg::CNT_W-1:0];
      regs[i].complete = (marked_cnt == span);
    end
    regs[regs.size()-1].last   = 1'b1;
    regs[regs.size()-1].trunc  = cut;
    regs[regs.size()-1].resume = resume[crbm_pkg::LEN_W-1:0];
    foreach (regs[i]) region_exp.push_back(regs[i]);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void add_req(crbm_pkg::op_t op, int unsigned start, int unsigned len);
    map_req_t req;
    req.op    = op;
    req.start = start[crbm_pkg::OFF_W-1:0];
    req.len   = len[crbm_pkg::LEN_W-1:0];
    req_pending.push_back(req);
  endfunction

  // Random requests, mostly inside the binary, mostly appends
  function automatic void queue_random(int count, int unsigned span);
    int unsigned   lim;
    int unsigned   pick;
    int unsigned   start;
    int unsigned   len;
    crbm_pkg::op_t op;
    lim = (span > crbm_pkg::BIN_CAPACITY) ? crbm_pkg::BIN_CAPACITY : span;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      op = crbm_pkg::OP_APPEND;
      else if (pick < 75) op = crbm_pkg::OP_SKIP;
      else if (pick < 92) op = crbm_pkg::OP_UNSKIP;
      else                op = crbm_pkg::OP_CLEAR;
      if (lim > 0 && $urandom_range(0, 4) != 0) start = $urandom_range(0, lim - 1);
      else                                      start = $urandom_range(0, 65535);
      pick = $urandom_range(0, 19);
      if (pick < 11)      len = $urandom_range(0, 64);
      else if (pick < 16) len = $urandom_range(0, 1024);
      else if (pick < 19) len = $urandom_range(0, 65536);
      else                len = 65536;
      add_req(op, start, len);
    end
  endfunction

  // APB write: setup then access; the register takes the value at the access edge
  task automatic write_reg(logic [crbm_pkg::APB_AW-1:0] addr, int unsigned value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    apply_config(addr, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (req_pending.size() != 0 || drv_valid || region_exp.size() != 0);
  endtask

  task automatic run_random(int unsigned bin, int unsigned blk, int count);
    write_reg(ADDR_BIN_LENGTH, bin);
    write_reg(ADDR_MAX_BLOCK, blk);
    queue_random(count, bin);
    wait_drained();
  endtask

  // Request driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (drv_valid && in_ch.ready) predict_regions(drv_req);
      if (!drv_valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left  <= gap_left - 1;
          drv_valid <= 1'b0;
        end else if (req_pending.size() > 0) begin
          drv_req   <= req_pending.pop_front();
          drv_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with its own stall pattern and one long hold-off
  int hold_left = 0;
  int pace_mode = 0;
  int pace_cnt  = 0;
  region_rec_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
      hold_left  <= 0;
      pace_mode  <= 0;
      pace_cnt   <= 0;
    end else begin
      if (out_ch.valid && sink_ready) begin
        if (region_exp.size() == 0) begin
          $error("unexpected result: offset %0d length %0d", out_ch.region_offset,
                 out_ch.region_length);
          mismatches++;
        end else begin
          want = region_exp.pop_front();
          check_field("region_offset", 32'(want.off), 32'(out_ch.region_offset));
          check_field("region_length", 32'(want.len), 32'(out_ch.region_length));
          check_field("last_result", 32'(want.last), 32'(out_ch.last_result));
          check_field("truncated", 32'(want.trunc), 32'(out_ch.truncated));
          check_field("resume_offset", 32'(want.resume), 32'(out_ch.resume_offset));
          check_field("mapped_total", 32'(want.total), 32'(out_ch.mapped_total));
          check_field("map_complete", 32'(want.complete), 32'(out_ch.map_complete));
        end
      end
      if (pace_cnt == 0) begin
        pace_mode <= $urandom_range(0, 3);
        pace_cnt  <= $urandom_range(16, 80);
      end else begin
        pace_cnt <= pace_cnt - 1;
      end
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        sink_ready <= 1'b0;
      end else if (long_hold_req && !long_hold_done && out_ch.valid && sink_ready) begin
        // results are flowing: stop taking them so the block backs up
        long_hold_done <= 1'b1;
        hold_left      <= LONG_HOLD;
        sink_ready     <= 1'b0;
      end else begin
        case (pace_mode)
          0:       sink_ready <= 1'b1;
          1:       sink_ready <= ($urandom_range(0, 3) != 0);
          2:       sink_ready <= ($urandom_range(0, 3) == 0);
          default: sink_ready <= $urandom_range(0, 1) != 0;
        endcase
      end
    end
  end

  // Watchdog: cycles without any handshake
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((drv_valid && in_ch.ready) || (out_ch.valid && sink_ready) || (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus sequence
  initial begin
    wipe_map();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // small binary, no block limit: runs, clipping, remapping, clear
    write_reg(ADDR_BIN_LENGTH, 1000);
    write_reg(ADDR_MAX_BLOCK, 0);
    add_req(crbm_pkg::OP_APPEND, 0, 0);
    add_req(crbm_pkg::OP_APPEND, 10, 20);
    add_req(crbm_pkg::OP_APPEND, 0, 100);
    add_req(crbm_pkg::OP_APPEND, 5, 10);
    add_req(crbm_pkg::OP_APPEND, 900, 65536);
    add_req(crbm_pkg::OP_APPEND, 65535, 65536);
    add_req(crbm_pkg::OP_SKIP, 200, 50);
    add_req(crbm_pkg::OP_APPEND, 150, 200);
    add_req(crbm_pkg::OP_UNSKIP, 0, 30);
    add_req(crbm_pkg::OP_APPEND, 0, 40);
    add_req(crbm_pkg::OP_CLEAR, 0, 0);
    add_req(crbm_pkg::OP_APPEND, 0, 1000);
    add_req(crbm_pkg::OP_SKIP, 0, 65536);
    wait_drained();

    // empty binary counts as complete
    write_reg(ADDR_BIN_LENGTH, 0);
    add_req(crbm_pkg::OP_APPEND, 0, 10);
    add_req(crbm_pkg::OP_UNSKIP, 65535, 65536);
    wait_drained();

    // one-byte blocks hit the region cap
    write_reg(ADDR_BIN_LENGTH, 65536);
    write_reg(ADDR_MAX_BLOCK, 1);
    add_req(crbm_pkg::OP_APPEND, 0, 200);
    add_req(crbm_pkg::OP_APPEND, 21845, 3);
    wait_drained();

    // full binary twice drives the mapped total into saturation
    write_reg(ADDR_MAX_BLOCK, 65536);
    add_req(crbm_pkg::OP_APPEND, 0, 65536);
    add_req(crbm_pkg::OP_UNSKIP, 0, 65536);
    add_req(crbm_pkg::OP_APPEND, 0, 65536);
    add_req(crbm_pkg::OP_APPEND, 0, 65535);
    wait_drained();

    // length register above capacity
    write_reg(ADDR_BIN_LENGTH, 32'h1FFFF);
    write_reg(ADDR_MAX_BLOCK, 0);
    add_req(crbm_pkg::OP_APPEND, 65535, 1);
    add_req(crbm_pkg::OP_SKIP, 0, 65535);
    wait_drained();

    // random phases
    long_hold_req <= 1'b1;
    run_random(65536, 0, 25);
    run_random(4096, $urandom_range(1, 16), 25);
    run_random($urandom_range(1, 2000), 3, 20);
    run_random(300, $urandom_range(0, 64), 17);

    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
